// ----- src/pcqs_pkg.sv -----
package pcqs_pkg;

  localparam int MaxPositionsDef = 256;
  localparam int QualityBinsDef  = 128;

  localparam logic [6:0] EmptyMin = 7'd127;

  typedef logic [31:0] cnt_t;
  typedef logic [38:0] sum_t;

  localparam logic [2:0] TALLY_A     = 3'd0;
  localparam logic [2:0] TALLY_C     = 3'd1;
  localparam logic [2:0] TALLY_G     = 3'd2;
  localparam logic [2:0] TALLY_T     = 3'd3;
  localparam logic [2:0] TALLY_OTHER = 3'd4;

  typedef struct packed {
    cnt_t            count;
    logic [6:0]      qmin;
    logic [6:0]      qmax;
    sum_t            total;
    cnt_t [4:0]      tally;
  } pos_row_t;

  typedef struct packed {
    logic       clear;
    logic       sum_en;
    logic       kset;
    logic       walk_en;
    logic [6:0] idx;
  } pcqs_walk_ctl_t;

  function automatic logic [2:0] tally_slot(input logic [7:0] letter);
    logic [7:0] u;
    u = letter;
    if (u >= 8'h61 && u <= 8'h7a) u = u - 8'd32;
    case (u)
      8'h41:   tally_slot = TALLY_A;
      8'h43:   tally_slot = TALLY_C;
      8'h47:   tally_slot = TALLY_G;
      8'h54:   tally_slot = TALLY_T;
      default: tally_slot = TALLY_OTHER;
    endcase
  endfunction

  function automatic cnt_t sat_inc(input cnt_t x);
    sat_inc = (x == '1) ? x : x + 32'd1;
  endfunction

endpackage

// ----- src/pcqs_if.sv -----
interface pcqs_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] position;
  logic [7:0] base_letter;
  logic [6:0] quality_code;

  modport source (output valid, kind, position, base_letter, quality_code, input ready);
  modport sink (input valid, kind, position, base_letter, quality_code, output ready);
endinterface

interface pcqs_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] observed_count;
  logic [6:0]  lowest_quality;
  logic [6:0]  highest_quality;
  logic [38:0] quality_total;
  logic [8:0]  first_quartile_x4;
  logic [8:0]  median_x4;
  logic [8:0]  third_quartile_x4;
  logic [31:0] count_a;
  logic [31:0] count_c;
  logic [31:0] count_g;
  logic [31:0] count_t;
  logic [31:0] count_other;

  modport source (output valid, observed_count, lowest_quality, highest_quality,
                  quality_total, first_quartile_x4, median_x4, third_quartile_x4,
                  count_a, count_c, count_g, count_t, count_other, input ready);
  modport sink (input valid, observed_count, lowest_quality, highest_quality,
                quality_total, first_quartile_x4, median_x4, third_quartile_x4,
                count_a, count_c, count_g, count_t, count_other, output ready);
endinterface

// ----- src/pcqs_qsel.sv -----
module pcqs_qsel (
  input  logic                    clk,
  input  pcqs_pkg::pcqs_walk_ctl_t ctl,
  input  pcqs_pkg::cnt_t          bin,
  output logic [2:0][8:0]         q_x4
);
  import pcqs_pkg::*;

  logic [38:0] n_r;
  logic [38:0] tot_r;
  logic [38:0] tot_nxt;
  logic [40:0] nm1;
  logic [40:0] q4 [3];
  logic [38:0] k_r [3];
  logic [1:0]  f_r [3];
  logic [6:0]  v_r [3];
  logic [6:0]  w_r [3];
  logic [2:0]  hv_r;
  logic [2:0]  hw_r;

  assign tot_nxt = tot_r + 39'(bin);
  assign nm1     = {2'b00, n_r} - 41'd1;
  assign q4[0]   = nm1;
  assign q4[1]   = {nm1[39:0], 1'b0};
  assign q4[2]   = {nm1[39:0], 1'b0} + nm1;

  always_ff @(posedge clk) begin
    if (ctl.clear) n_r <= '0;
    else if (ctl.sum_en) n_r <= n_r + 39'(bin);
    if (ctl.kset) begin
      tot_r <= '0;
      hv_r  <= '0;
      hw_r  <= '0;
      for (int j = 0; j < 3; j++) begin
        k_r[j] <= q4[j][40:2];
        f_r[j] <= q4[j][1:0];
        // w may never be found when the fraction is zero
        v_r[j] <= '0;
        w_r[j] <= '0;
      end
    end else if (ctl.walk_en) begin
      tot_r <= tot_nxt;
      for (int j = 0; j < 3; j++) begin
        if (!hv_r[j] && tot_nxt > k_r[j]) begin
          v_r[j]  <= ctl.idx;
          hv_r[j] <= 1'b1;
        end
        if (!hw_r[j] && {1'b0, tot_nxt} > ({1'b0, k_r[j]} + 40'd1)) begin
          w_r[j]  <= ctl.idx;
          hw_r[j] <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    logic [9:0] q;
    for (int j = 0; j < 3; j++) begin
      q = {1'b0, v_r[j], 2'b00} + 10'(f_r[j]) * 10'(w_r[j] - v_r[j]);
      q_x4[j] = q[8:0];
    end
  end

endmodule

// ----- src/per_cycle_quality_stats.sv -----
// Channel   Dir  Beat contents
// in_ch     in   kind, position, base_letter, quality_code
// out_ch    out  count, min, max, sum, three quartiles x4, five base tallies
//
// Observe: histogram and position row read, then write back.
// Report: two walks over the histogram memory port.
// After reset a clearing pass over all MAX_POSITIONS*QUALITY_BINS histogram entries
// (32768 by default) zeroes both memories; no input is taken meanwhile.
// A result waiting in the output register does not block new input; only a second report waits for it in S_FIN.
module per_cycle_quality_stats #(
  parameter int MAX_POSITIONS = pcqs_pkg::MaxPositionsDef,
  parameter int QUALITY_BINS  = pcqs_pkg::QualityBinsDef
) (
  input logic       clk,
  input logic       rst_n,
  pcqs_in_if.sink   in_ch,
  pcqs_out_if.source out_ch
);
  import pcqs_pkg::*;

  localparam int PW     = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
  localparam int BW     = $clog2(QUALITY_BINS);
  localparam int HDEPTH = MAX_POSITIONS * QUALITY_BINS;
  localparam int HAW    = $clog2(HDEPTH);
  localparam logic [6:0] ClampCode = 7'(((QUALITY_BINS - 1) < 126) ? (QUALITY_BINS - 1) : 126);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_OBS_WB, S_RPT_ROW, S_SUM, S_SUM_DRAIN,
    S_KSET, S_WALK, S_WALK_DRAIN, S_FIN
  } state_t;

  cnt_t     hist_mem [HDEPTH];
  pos_row_t row_mem  [MAX_POSITIONS];

  state_t      state_r;
  logic [PW-1:0] clr_pos_r;
  logic [BW-1:0] clr_bin_r;
  logic [PW-1:0] pos_r;
  logic [6:0]  code_r;
  logic [2:0]  slot_r;
  logic [HAW-1:0] haddr_r;
  logic [6:0]  lo_r, hi_r, walk_i_r, rd_idx_r;
  logic        rd_pend_r, zero_r;
  pos_row_t    row_r;
  cnt_t        hist_q_r;
  pos_row_t    row_q_r;

  logic        out_valid_r;
  pos_row_t    out_row_r;
  logic [2:0][8:0] out_q_r;

  logic        in_accept, in_oor;
  logic [PW-1:0] in_pos;
  logic [6:0]  in_code;
  logic [HAW-1:0] hrd_addr, hwr_addr;
  logic        hrd_en, hwe, rwe;
  cnt_t        hwd;
  logic [PW-1:0] rwr_addr;
  pos_row_t    rwd, row_upd, row_empty, row_fin;
  logic [39:0] sum_ext;
  logic [6:0]  qlo, qhi;
  logic        out_free;
  pcqs_walk_ctl_t wctl;
  logic [2:0][8:0] qres;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign in_pos      = PW'(in_ch.position);
  assign in_oor      = {24'd0, in_ch.position} >= 32'(MAX_POSITIONS);
  assign in_code     = (in_ch.quality_code > ClampCode) ? ClampCode : in_ch.quality_code;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign qlo = (row_q_r.qmin > ClampCode) ? ClampCode : row_q_r.qmin;
  assign qhi = (row_q_r.qmax > ClampCode) ? ClampCode : row_q_r.qmax;

  always_comb begin
    row_empty       = '0;
    row_empty.qmin  = EmptyMin;
    row_fin         = row_r;
    row_fin.qmin    = lo_r;
    row_fin.qmax    = hi_r;
    hrd_en   = in_accept || state_r == S_SUM || state_r == S_WALK;
    hrd_addr = (state_r == S_IDLE)
             ? HAW'(HAW'(in_pos) * HAW'(QUALITY_BINS) + HAW'(in_code))
             : HAW'(HAW'(pos_r) * HAW'(QUALITY_BINS) + HAW'(walk_i_r));
    row_upd       = row_q_r;
    row_upd.count = sat_inc(row_q_r.count);
    if (code_r < row_q_r.qmin) row_upd.qmin = code_r;
    if (code_r > row_q_r.qmax) row_upd.qmax = code_r;
    sum_ext       = {1'b0, row_q_r.total} + 40'(code_r);
    row_upd.total = sum_ext[39] ? '1 : sum_ext[38:0];
    row_upd.tally[slot_r] = sat_inc(row_q_r.tally[slot_r]);
    if (state_r == S_CLEAR) begin
      hwe      = 1'b1;
      hwr_addr = HAW'(HAW'(clr_pos_r) * HAW'(QUALITY_BINS) + HAW'(clr_bin_r));
      hwd      = '0;
      rwe      = (clr_bin_r == '0);
      rwr_addr = clr_pos_r;
      rwd      = row_empty;
    end else begin
      hwe      = (state_r == S_OBS_WB);
      hwr_addr = haddr_r;
      hwd      = sat_inc(hist_q_r);
      rwe      = (state_r == S_OBS_WB);
      rwr_addr = pos_r;
      rwd      = row_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (hrd_en) hist_q_r <= hist_mem[hrd_addr];
    if (hwe) hist_mem[hwr_addr] <= hwd;
    if (in_accept) row_q_r <= row_mem[in_pos];
    if (rwe) row_mem[rwr_addr] <= rwd;
  end

  always_comb begin
    wctl.clear   = (state_r == S_RPT_ROW);
    wctl.sum_en  = rd_pend_r && (state_r == S_SUM || state_r == S_SUM_DRAIN);
    wctl.kset    = (state_r == S_KSET);
    wctl.walk_en = rd_pend_r && (state_r == S_WALK || state_r == S_WALK_DRAIN);
    wctl.idx     = rd_idx_r;
  end

  pcqs_qsel u_qsel (
    .clk  (clk),
    .ctl  (wctl),
    .bin  (hist_q_r),
    .q_x4 (qres)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_pos_r   <= '0;
      clr_bin_r   <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_pend_r <= (state_r == S_SUM || state_r == S_WALK);
      rd_idx_r  <= walk_i_r;
      if (state_r == S_FIN && out_free) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          if (clr_bin_r == BW'(QUALITY_BINS - 1)) begin
            clr_bin_r <= '0;
            if (clr_pos_r == PW'(MAX_POSITIONS - 1)) state_r <= S_IDLE;
            else clr_pos_r <= clr_pos_r + 1'b1;
          end else begin
            clr_bin_r <= clr_bin_r + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_accept) begin
            pos_r   <= in_pos;
            code_r  <= in_code;
            slot_r  <= tally_slot(in_ch.base_letter);
            haddr_r <= hrd_addr;
            zero_r  <= in_oor;
            if (!in_ch.kind) state_r <= in_oor ? S_IDLE : S_OBS_WB;
            else state_r <= in_oor ? S_FIN : S_RPT_ROW;
          end
        end
        S_OBS_WB: state_r <= S_IDLE;
        S_RPT_ROW: begin
          row_r    <= row_q_r;
          lo_r     <= qlo;
          hi_r     <= qhi;
          walk_i_r <= qlo;
          if (row_q_r.count == '0) begin
            zero_r  <= 1'b1;
            state_r <= S_FIN;
          end else begin
            state_r <= S_SUM;
          end
        end
        S_SUM: begin
          if (walk_i_r == hi_r) state_r <= S_SUM_DRAIN;
          else walk_i_r <= walk_i_r + 7'd1;
        end
        S_SUM_DRAIN: state_r <= S_KSET;
        S_KSET: begin
          walk_i_r <= lo_r;
          state_r  <= S_WALK;
        end
        S_WALK: begin
          if (walk_i_r == hi_r) state_r <= S_WALK_DRAIN;
          else walk_i_r <= walk_i_r + 7'd1;
        end
        S_WALK_DRAIN: state_r <= S_FIN;
        S_FIN: begin
          if (out_free) begin
            if (zero_r) begin
              out_row_r <= '0;
              out_q_r   <= '0;
            end else begin
              out_row_r <= row_fin;
              out_q_r   <= qres;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.observed_count    = out_row_r.count;
  assign out_ch.lowest_quality    = out_row_r.qmin;
  assign out_ch.highest_quality   = out_row_r.qmax;
  assign out_ch.quality_total     = out_row_r.total;
  assign out_ch.first_quartile_x4 = out_q_r[0];
  assign out_ch.median_x4         = out_q_r[1];
  assign out_ch.third_quartile_x4 = out_q_r[2];
  assign out_ch.count_a           = out_row_r.tally[TALLY_A];
  assign out_ch.count_c           = out_row_r.tally[TALLY_C];
  assign out_ch.count_g           = out_row_r.tally[TALLY_G];
  assign out_ch.count_t           = out_row_r.tally[TALLY_T];
  assign out_ch.count_other       = out_row_r.tally[TALLY_OTHER];

  a_no_input_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> !in_ch.ready)
    else $error("input taken during clearing pass");

  a_writeback_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OBS_WB |-> $past(state_r) == S_IDLE && $past(in_accept))
    else $error("write back without an accepted beat");

  a_fin_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN && out_free |=> out_valid_r && state_r == S_IDLE)
    else $error("report result not loaded");

endmodule

// ----- dv/tb_per_cycle_quality_stats.sv -----
`timescale 1ns / 100ps

module tb_per_cycle_quality_stats;
  import pcqs_pkg::*;

  localparam int NumPos      = 256;
  localparam int ClampCode   = 126;
  localparam int RandomItems = 750;
  localparam int IdleLimit   = 150000;  // covers the clearing pass after reset
  localparam int TailCycles  = 400;
  localparam logic [38:0] SumMax = '1;

  localparam logic KIND_OBSERVE = 1'b0;
  localparam logic KIND_REPORT  = 1'b1;

  typedef struct {
    logic       kind;
    logic [7:0] position;
    logic [7:0] letter;
    logic [6:0] code;
    bit         hold;  // sender waits here until all reports are back
  } beat_t;

  typedef struct {
    cnt_t        count;
    logic [6:0]  qmin;
    logic [6:0]  qmax;
    sum_t        total;
    logic [8:0]  q1;
    logic [8:0]  q2;
    logic [8:0]  q3;
    cnt_t        tally [5];
  } stats_t;

  logic clk;
  logic rst_n;

  pcqs_in_if  in_ch ();
  pcqs_out_if out_ch ();

  per_cycle_quality_stats u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  // Own copy of the per-position statistics
  int unsigned hist [NumPos][128];
  int unsigned pos_count [NumPos];
  int unsigned pos_min [NumPos];
  int unsigned pos_max [NumPos];
  logic [39:0] pos_sum [NumPos];
  int unsigned pos_tally [NumPos][5];

  beat_t  pending [$];
  stats_t expected_reports [$];

  int errors = 0;
  int reports_seen = 0;
  int observes_sent = 0;
  int idle_cycles = 0;
  bit finishing = 0;

  function automatic int letter_slot(logic [7:0] letter);
    logic [7:0] u;
    u = letter;
    if (u >= "a" && u <= "z") u = u - 8'd32;
    if (u == "A") return 0;
    if (u == "C") return 1;
    if (u == "G") return 2;
    if (u == "T") return 3;
    return 4;
  endfunction

  function automatic int unsigned bump(int unsigned x);
    return (x == 32'hFFFF_FFFF) ? x : x + 1;
  endfunction

  function automatic logic [8:0] quartile_x4(int p, int lo, int hi, int quarters);
    longint n, tot, v, w, q4, k, f;
    bit have_v;
    n = 0; tot = 0; v = 0; w = 0; have_v = 0;
    for (int i = lo; i <= hi; i++) n += hist[p][i];
    if (n == 0) return '0;
    q4 = quarters * (n - 1);
    k = q4 >> 2;
    f = q4 & 3;
    for (int i = lo; i <= hi; i++) begin
      tot += hist[p][i];
      if (!have_v && tot > k) begin
        v = i;
        have_v = 1;
      end
      if (tot > k + 1) begin
        w = i;
        break;
      end
    end
    if (f == 0) return 9'(4 * v);
    return 9'(4 * v + f * (w - v));
  endfunction

  task automatic record_base(int p, logic [7:0] letter, logic [6:0] raw);
    int code;
    int slot;
    code = (raw > ClampCode) ? ClampCode : int'(raw);
    slot = letter_slot(letter);
    hist[p][code] = bump(hist[p][code]);
    pos_count[p] = bump(pos_count[p]);
    if (code < pos_min[p]) pos_min[p] = code;
    if (code > pos_max[p]) pos_max[p] = code;
    pos_sum[p] = pos_sum[p] + code;
    if (pos_sum[p] > SumMax) pos_sum[p] = SumMax;
    pos_tally[p][slot] = bump(pos_tally[p][slot]);
  endtask

  function automatic stats_t position_stats(int p);
    stats_t s;
    int lo, hi;
    s.count = '0; s.qmin = '0; s.qmax = '0; s.total = '0;
    s.q1 = '0; s.q2 = '0; s.q3 = '0;
    for (int j = 0; j < 5; j++) s.tally[j] = '0;
    if (pos_count[p] == 0) return s;
    lo = (pos_min[p] > ClampCode) ? ClampCode : pos_min[p];
    hi = (pos_max[p] > ClampCode) ? ClampCode : pos_max[p];
    s.count = pos_count[p];
    s.qmin = 7'(lo);
    s.qmax = 7'(hi);
    s.total = pos_sum[p][38:0];
    s.q1 = quartile_x4(p, lo, hi, 1);
    s.q2 = quartile_x4(p, lo, hi, 2);
    s.q3 = quartile_x4(p, lo, hi, 3);
    for (int j = 0; j < 5; j++) s.tally[j] = pos_tally[p][j];
    return s;
  endfunction

  task automatic push_beat(logic kind, logic [7:0] p, logic [7:0] letter, logic [6:0] code);
    beat_t b;
    b.kind = kind; b.position = p; b.letter = letter; b.code = code; b.hold = 0;
    pending = {pending, b};
  endtask

  task automatic push_hold();
    beat_t b;
    b = '{kind: KIND_OBSERVE, position: '0, letter: '0, code: '0, hold: 1};
    pending = {pending, b};
  endtask

  // Sender: bursts of random length, random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.kind <= KIND_OBSERVE;
      in_ch.position <= '0;
      in_ch.base_letter <= '0;
      in_ch.quality_code <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid && in_ch.ready && in_ch.kind == KIND_REPORT)
        ; // predicted by the acceptance block below
      while (pending.size() > 0 && pending[0].hold && expected_reports.size() == 0 &&
             !(in_ch.valid && in_ch.ready && in_ch.kind == KIND_REPORT))
        void'(pending.pop_front());
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (pending.size() == 0 || pending[0].hold) begin
        in_ch.valid <= 1'b0;
      end else begin
        beat_t b;
        b = pending.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.kind <= b.kind;
        in_ch.position <= b.position;
        in_ch.base_letter <= b.letter;
        in_ch.quality_code <= b.code;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 15);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // Predict on every accepted input beat
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      if (in_ch.kind == KIND_OBSERVE) begin
        record_base(in_ch.position, in_ch.base_letter, in_ch.quality_code);
        observes_sent++;
      end else begin
        expected_reports = {expected_reports, position_stats(in_ch.position)};
      end
    end
  end

  // Receiver: stall pattern is picked at random from four patterns
  int stall_phase = 0;
  int cyc = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      cyc++;
      if (cyc % 64 == 0) stall_phase = $urandom_range(0, 3);
      case (stall_phase)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= ($urandom_range(0, 1) == 1);
        2:       out_ch.ready <= ($urandom_range(0, 7) == 0);
        default: out_ch.ready <= (cyc % 5 != 0);
      endcase
    end
  end

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      stats_t e;
      reports_seen++;
      if (expected_reports.size() == 0) begin
        errors++;
        $display("%0t: report beat with nothing expected", $time);
      end else begin
        e = expected_reports.pop_front();
        check_field("observed_count", e.count, out_ch.observed_count);
        check_field("lowest_quality", e.qmin, out_ch.lowest_quality);
        check_field("highest_quality", e.qmax, out_ch.highest_quality);
        check_field("quality_total", e.total, out_ch.quality_total);
        check_field("first_quartile_x4", e.q1, out_ch.first_quartile_x4);
        check_field("median_x4", e.q2, out_ch.median_x4);
        check_field("third_quartile_x4", e.q3, out_ch.third_quartile_x4);
        check_field("count_a", e.tally[0], out_ch.count_a);
        check_field("count_c", e.tally[1], out_ch.count_c);
        check_field("count_g", e.tally[2], out_ch.count_g);
        check_field("count_t", e.tally[3], out_ch.count_t);
        check_field("count_other", e.tally[4], out_ch.count_other);
      end
    end
  end

  // Watchdog on cycles without any beat
  always @(posedge clk) begin
    if (rst_n && !finishing) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("%0t: no progress for %0d cycles", $time, IdleLimit);
        $display("** per_cycle_quality_stats: FAILED **");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    logic [7:0] hot [6];
    byte unsigned letters [8];
    int qbase;
    logic [7:0] p;
    logic [7:0] letter;
    logic [6:0] code;

    letters = '{"A", "C", "G", "T", "a", "c", "g", "t"};
    for (int i = 0; i < NumPos; i++) begin
      pos_count[i] = 0; pos_min[i] = 127; pos_max[i] = 0; pos_sum[i] = '0;
      for (int j = 0; j < 5; j++) pos_tally[i][j] = 0;
      for (int j = 0; j < 128; j++) hist[i][j] = 0;
    end

    rst_n = 1'b0;

    // directed: empty reports, extremes, every letter class, clamping
    push_beat(KIND_REPORT, 8'd0, 8'h00, 7'd0);
    push_beat(KIND_OBSERVE, 8'd0, "A", 7'd0);
    push_beat(KIND_REPORT, 8'd0, 8'h00, 7'd0);
    push_beat(KIND_OBSERVE, 8'd0, "c", 7'd127);
    push_beat(KIND_OBSERVE, 8'd0, "G", 7'd126);
    push_beat(KIND_OBSERVE, 8'd0, "t", 7'd40);
    push_beat(KIND_OBSERVE, 8'd0, "N", 7'd33);
    push_beat(KIND_OBSERVE, 8'd0, 8'hFF, 7'd1);
    push_beat(KIND_OBSERVE, 8'd0, 8'h00, 7'd64);
    push_beat(KIND_OBSERVE, 8'd0, "z", 7'd2);
    push_beat(KIND_REPORT, 8'd0, 8'hFF, 7'd127);
    push_beat(KIND_OBSERVE, 8'd255, "T", 7'd127);
    push_beat(KIND_REPORT, 8'd255, 8'h00, 7'd0);
    push_beat(KIND_OBSERVE, 8'd255, "g", 7'd127);
    push_beat(KIND_OBSERVE, 8'd255, "a", 7'd0);
    push_beat(KIND_REPORT, 8'd255, 8'h00, 7'd0);
    push_beat(KIND_OBSERVE, 8'd170, "C", 7'd85);
    push_beat(KIND_OBSERVE, 8'd85, "@", 7'd42);
    push_beat(KIND_REPORT, 8'd170, 8'h00, 7'd0);
    push_beat(KIND_REPORT, 8'd85, 8'h00, 7'd0);
    push_beat(KIND_REPORT, 8'd200, 8'h00, 7'd0);
    push_hold();

    // random: a few hot positions build deep histograms, the rest spreads out
    for (int i = 0; i < 6; i++) hot[i] = $urandom_range(0, 255);
    hot[0] = 8'd0;
    hot[1] = 8'd255;
    for (int i = 0; i < RandomItems; i++) begin
      p = ($urandom_range(0, 9) < 7) ? hot[$urandom_range(0, 5)] : 8'($urandom_range(0, 255));
      letter = ($urandom_range(0, 9) < 7) ? letters[$urandom_range(0, 7)]
                                          : 8'($urandom_range(0, 255));
      qbase = 20 + 8 * (p % 8);
      code = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127))
                                         : 7'(qbase + $urandom_range(0, 25));
      push_beat(($urandom_range(0, 99) < 18) ? KIND_REPORT : KIND_OBSERVE, p, letter, code);
      if (i == RandomItems / 2) push_hold();
    end
    for (int i = 0; i < 6; i++) push_beat(KIND_REPORT, hot[i], 8'h00, 7'd0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending.size() == 0);
    @(posedge clk);
    while (in_ch.valid) @(posedge clk);
    while (expected_reports.size() != 0) @(posedge clk);
    finishing = 1;
    repeat (TailCycles) @(posedge clk);

    $display("Covered %0d observe beats and %0d reports, incl. empty and clamped cases,",
             observes_sent, reports_seen);
    $display("with bursty input and a varying result stall pattern.");
    if (errors == 0 && expected_reports.size() == 0) begin
      $display("** per_cycle_quality_stats: PASSED **");
    end else begin
      $display("%0d mismatches, %0d reports outstanding", errors, expected_reports.size());
      $display("** per_cycle_quality_stats: FAILED **");
    end
    $finish;
  end

endmodule
